// ===== hdl/isr_pkg.sv =====
// Shared types and constants for the restoring integer square root.
// Used by the root cell and the top level; depends on nothing else.
package isr_pkg;

  localparam int WIDTH      = 32;              // radicand width
  localparam int PAIRS      = (WIDTH + 1) / 2; // root bits, one cell each
  localparam int PAD_W      = 2 * PAIRS;       // radicand padded to whole bit pairs
  localparam int REM_W      = PAIRS + 1;       // partial remainder, at most twice the root
  localparam int ROOT_OUT_W = 16;
  localparam int REM_OUT_W  = 17;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // What one cell hands to the next.
  typedef struct packed {
    logic             valid;
    logic [PAD_W-1:0] rad;   // radicand bits still to use, next pair at the top
    logic [REM_W-1:0] rem;
    logic [PAIRS-1:0] root;
  } isr_stage_t;

endpackage

// ===== hdl/isr_cell.sv =====
// One cell of the square root chain: brings in the next radicand bit pair,
// tries the trial subtraction and registers one more root bit. Uses isr_pkg.
module isr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  isr_pkg::isr_stage_t up,
  output logic               up_ready,
  output isr_pkg::isr_stage_t down,
  input  logic               down_ready
);
  import isr_pkg::*;

  logic             valid_r;
  logic [PAD_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [PAIRS-1:0] root_r, root_nxt;
  logic [PAIRS+2:0] rem_cat;
  logic [PAIRS+2:0] trial;
  logic [PAIRS+2:0] diff;
  logic             fits;

  always_comb begin
    rem_cat  = {up.rem, up.rad[PAD_W-1 -: 2]};
    trial    = (PAIRS+3)'({up.root, 2'b01});
    fits     = (rem_cat >= trial);
    diff     = rem_cat - trial;
    // The remainder stays within twice the root, so the truncation loses nothing.
    rem_nxt  = fits ? REM_W'(diff) : REM_W'(rem_cat);
    root_nxt = PAIRS'({up.root, fits});
    rad_nxt  = PAD_W'({up.rad, 2'b00});
  end

  assign up_ready = !valid_r || down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up.valid) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign down.valid = valid_r;
  assign down.rad   = rad_r;
  assign down.rem   = rem_r;
  assign down.root  = root_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ({1'b0, rem_r} <= {root_r, 1'b0}))
    else $error("cell remainder exceeds twice the partial root");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !down_ready |=> valid_r && $stable(root_r) && $stable(rem_r))
    else $error("stalled cell lost or changed its request");

endmodule

// ===== hdl/restoring_integer_square_root_top.sv =====
// Restoring integer square root: a chain of one cell per root bit.
// Each accepted request passes through the registers of every cell in turn; its result leaves the last cell.
// Throughput: one request per cycle while the output is ready; a stalled output fills the empty cells first.
// Reset (rst_n low, synchronous) empties every cell; payload is not cleared.
// Uses isr_pkg and isr_cell.
module restoring_integer_square_root_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [isr_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] radicand
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [isr_pkg::OUT_DATA_W-1:0] out_tdata   // [15:0] root, [32:16] remainder
);
  import isr_pkg::*;

  isr_stage_t             stg [PAIRS+1];
  logic       [PAIRS:0]   rdy;
  logic       [PAIRS-1:0] busy;

  assign stg[0].valid = in_tvalid;
  assign stg[0].rad   = PAD_W'(in_tdata[WIDTH-1:0]);
  assign stg[0].rem   = '0;
  assign stg[0].root  = '0;
  assign in_tready    = rdy[0];
  assign rdy[PAIRS]   = out_tready;

  for (genvar k = 0; k < PAIRS; k++) begin : g_cell
    isr_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up         (stg[k]),
      .up_ready   (rdy[k]),
      .down       (stg[k+1]),
      .down_ready (rdy[k+1])
    );
    assign busy[k] = stg[k+1].valid;
  end

  assign out_tvalid = stg[PAIRS].valid;
  assign out_tdata  = OUT_DATA_W'({REM_OUT_W'(stg[PAIRS].rem), ROOT_OUT_W'(stg[PAIRS].root)});

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&busy))
    else $error("input refused while a cell is empty");

  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[32:16]} <= {1'b0, out_tdata[15:0], 1'b0}))
    else $error("remainder exceeds twice the root");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !busy[PAIRS-2] |=> !out_tvalid)
    else $error("result repeated after it was taken");

endmodule
